>>> hw/rtl/sbs_pkg.sv
// Types and constants shared by the sorted bucket search block.
// No dependencies; used by sbs_front, sbs_queue, sbs_back and the top level.
`default_nettype none

package sbs_pkg;

	localparam int SCORE_W = 160;
	localparam int TYPE_W  = 8;
	localparam int SLOT_W  = 8;
	localparam int COUNT_W = 9;
	localparam int QDEPTH  = 2;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// One classified command between front and back.
	typedef struct packed {
		logic               is_search;
		logic [SLOT_W-1:0]  slot;
		logic [SCORE_W-1:0] score;
		logic [TYPE_W-1:0]  etype;
		logic               any;
		logic [COUNT_W-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/sbs_front.sv
// Front end: accepts input beats, drops out-of-range writes, clamps counts.
// Depends on sbs_pkg; feeds sbs_queue.
`default_nettype none

module sbs_front #(
	parameter int BUCKET_ENTRIES = 256
) (
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       func,
	input  wire logic [7:0]                 slot,
	input  wire logic [63:0]                score_a,
	input  wire logic [63:0]                score_b,
	input  wire logic [31:0]                score_c,
	input  wire logic [7:0]                 entry_type,
	input  wire logic                       any_type,
	input  wire logic [8:0]                 entry_count,
	input  wire sbs_pkg::q_stat_t           q_stat,
	output logic                            push,
	output sbs_pkg::cmd_t                   push_cmd
);

	logic slot_ok;

	assign in_ready = !q_stat.full;
	assign slot_ok  = 32'(slot) < BUCKET_ENTRIES;

	always_comb begin
		push_cmd.is_search = (func == sbs_pkg::FUNC_SEARCH);
		push_cmd.slot      = slot;
		push_cmd.score     = {score_a, score_b, score_c};
		push_cmd.etype     = entry_type;
		push_cmd.any       = any_type;
		// clamp the count to the bucket depth
		if (32'(entry_count) > BUCKET_ENTRIES) begin
			push_cmd.count = sbs_pkg::COUNT_W'(BUCKET_ENTRIES);
		end else begin
			push_cmd.count = entry_count;
		end
	end

	// drop writes aimed past the bucket
	assign push = in_valid && in_ready && (push_cmd.is_search || slot_ok);

endmodule

`default_nettype wire

>>> hw/rtl/sbs_queue.sv
// Short command queue between front and back.
// Depends on sbs_pkg (cmd_t, q_stat_t, QDEPTH).
`default_nettype none

module sbs_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sbs_pkg::cmd_t     push_cmd,
	input  wire logic              pop,
	output sbs_pkg::cmd_t          head,
	output sbs_pkg::q_stat_t       stat
);

	localparam int PW = (sbs_pkg::QDEPTH > 1) ? $clog2(sbs_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(sbs_pkg::QDEPTH + 1);

	sbs_pkg::cmd_t  slots_q [sbs_pkg::QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  fill_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		if (32'(p) == sbs_pkg::QDEPTH - 1) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	assign head       = slots_q[rd_ptr_q];
	assign stat.full  = (32'(fill_q) == sbs_pkg::QDEPTH);
	assign stat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/sbs_back.sv
// Back end: entry memory, binary search sequencer and result register.
// Depends on sbs_pkg; takes commands from sbs_queue.
`default_nettype none

module sbs_back #(
	parameter int BUCKET_ENTRIES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sbs_pkg::cmd_t     head,
	input  wire sbs_pkg::q_stat_t  q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   found,
	output logic [8:0]             position
);

	localparam int IW = (BUCKET_ENTRIES > 1) ? $clog2(BUCKET_ENTRIES) : 1;
	localparam int EW = sbs_pkg::SCORE_W + sbs_pkg::TYPE_W;
	localparam int NW = sbs_pkg::COUNT_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	logic [EW-1:0]               mem_q [BUCKET_ENTRIES];
	logic [EW-1:0]               rd_q;
	logic [1:0]                  state_q;
	logic [sbs_pkg::SCORE_W-1:0] key_q;
	logic [sbs_pkg::TYPE_W-1:0]  ktype_q;
	logic                        any_q;
	logic [NW-1:0]               lo_q;
	logic [NW-1:0]               hiex_q;
	logic [NW-1:0]               mid_q;
	logic                        res_found_q;
	logic [NW-1:0]               res_pos_q;
	logic                        out_valid_q;
	logic                        found_q;
	logic [NW-1:0]               position_q;

	logic            wr_en;
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic [NW-1:0]   mid0;
	logic            score_gt;
	logic            score_eq;
	logic            hit;
	logic            go_right;
	logic [NW-1:0]   lo_n;
	logic [NW-1:0]   hiex_n;
	logic [NW-1:0]   mid_n;
	logic            more;
	logic            out_free;

	assign pop   = (state_q == ST_IDLE) && !q_stat.empty;
	assign wr_en = pop && !head.is_search;
	assign mid0  = NW'((({1'b0, head.count}) - (NW+1)'(1)) >> 1);

	// compare key against the probed entry
	assign score_eq = (key_q == rd_q[EW-1:sbs_pkg::TYPE_W]);
	assign score_gt = (key_q >  rd_q[EW-1:sbs_pkg::TYPE_W]);
	assign hit      = score_eq && (any_q || (ktype_q == rd_q[sbs_pkg::TYPE_W-1:0]));
	assign go_right = score_gt ||
			(score_eq && !any_q && (ktype_q > rd_q[sbs_pkg::TYPE_W-1:0]));

	assign lo_n   = go_right ? (mid_q + NW'(1)) : lo_q;
	assign hiex_n = go_right ? hiex_q : mid_q;
	assign mid_n  = NW'((({1'b0, lo_n} + {1'b0, hiex_n}) - (NW+1)'(1)) >> 1);
	assign more   = (lo_n < hiex_n);

	assign rd_en   = (pop && head.is_search) || ((state_q == ST_SEARCH) && !hit && more);
	assign rd_addr = (state_q == ST_IDLE) ? IW'(mid0) : IW'(mid_n);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[IW'(head.slot)] <= {head.score, head.etype};
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop && head.is_search) begin
					key_q       <= head.score;
					ktype_q     <= head.etype;
					any_q       <= head.any;
					lo_q        <= '0;
					hiex_q      <= head.count;
					mid_q       <= mid0;
					res_found_q <= 1'b0;
					res_pos_q   <= '0;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					res_found_q <= 1'b1;
					res_pos_q   <= mid_q;
				end else begin
					lo_q        <= lo_n;
					hiex_q      <= hiex_n;
					mid_q       <= mid_n;
					res_found_q <= 1'b0;
					res_pos_q   <= lo_n;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					found_q    <= res_found_q;
					position_q <= res_pos_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// post a new beat, or drop the one just taken
			if ((state_q == ST_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && head.is_search) begin
						// an empty range ends at once
						state_q <= (head.count == '0) ? ST_RESULT : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit || !more) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

endmodule

`default_nettype wire

>>> hw/rtl/sorted_bucket_search_top.sv
// Sorted bucket search: entry store with binary search over sorted entries.
// Usage:
//   The input channel (in_valid/in_ready) takes one beat per command. func
//   selects a write (slot, score, entry_type go to one entry; no result) or a
//   search (score, entry_type, any_type, entry_count; exactly one result).
//   The output channel (out_valid/out_ready) returns found and position:
//   the matching entry index, or the index of the first greater entry.
//   Commands pass a two-deep queue, so the input keeps taking beats while
//   the back end searches or a result waits on out_ready.
//   A search probes the entry memory at most ceil(log2(count+1)) times (9
//   for 256 entries) between the pop and the result register. A write is
//   stored in the back end as it is popped. The back end pops a command
//   only when idle, so it finishes each search before it takes the next
//   one; the entry memory has a single read port.
//   Reset clears the queue, the sequencer and out_valid; entry contents are
//   undefined until written. A stalled receiver holds the result in the
//   output register; the back end then waits and the queue fills up.
// Depends on sbs_pkg, sbs_front, sbs_queue, sbs_back.
`default_nettype none

module sorted_bucket_search_top #(
	parameter int BUCKET_ENTRIES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        func,
	input  wire logic [7:0]  slot,
	input  wire logic [63:0] score_a,
	input  wire logic [63:0] score_b,
	input  wire logic [31:0] score_c,
	input  wire logic [7:0]  entry_type,
	input  wire logic        any_type,
	input  wire logic [8:0]  entry_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [8:0]       position
);

	logic              push;
	logic              pop;
	sbs_pkg::cmd_t     push_cmd;
	sbs_pkg::cmd_t     head;
	sbs_pkg::q_stat_t  q_stat;

	sbs_front #(
		.BUCKET_ENTRIES(BUCKET_ENTRIES)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.slot       (slot),
		.score_a    (score_a),
		.score_b    (score_b),
		.score_c    (score_c),
		.entry_type (entry_type),
		.any_type   (any_type),
		.entry_count(entry_count),
		.q_stat     (q_stat),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	sbs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.stat    (q_stat)
	);

	sbs_back #(
		.BUCKET_ENTRIES(BUCKET_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found    (found),
		.position (position)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("command pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("command popped from an empty queue");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (32'(position) < BUCKET_ENTRIES))
		else $error("found position outside the bucket");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (position <= 9'd256))
		else $error("result position above the largest count");

endmodule

`default_nettype wire

>>> tb/sv/sorted_bucket_search_top_tb.sv
// Self-checking testbench for sorted_bucket_search_top: writes sorted buckets,
// runs lookups under random sender gaps and receiver stalls, checks each result.
// Depends on sbs_pkg and the sorted_bucket_search_top RTL.
`timescale 1ns / 100ps

localparam int BUCKET = 256;

typedef struct packed {
	logic       hit;
	logic [8:0] pos;
} lookup_t;

// Holds its own copy of the bucket and the lookups still owed by the block.
class bucket_scoreboard;
	logic [sbs_pkg::SCORE_W-1:0] score_mem [BUCKET];
	logic [sbs_pkg::TYPE_W-1:0]  type_mem [BUCKET];
	lookup_t            owed_q [$];
	int                 errors;
	int                 hits;
	int                 misses;

	function new();
		errors = 0;
		hits = 0;
		misses = 0;
	endfunction

	function void note(sbs_pkg::cmd_t c);
		int      lo;
		int      hi;
		int      mid;
		int      ord;
		lookup_t res;
		if (c.is_search == sbs_pkg::FUNC_WRITE) begin
			if (int'(c.slot) < BUCKET) begin
				score_mem[c.slot] = c.score;
				type_mem[c.slot] = c.etype;
			end
			return;
		end
		lo = 0;
		hi = ((int'(c.count) > BUCKET) ? BUCKET : int'(c.count)) - 1;
		mid = 0;
		res.hit = 1'b0;
		while (lo <= hi && !res.hit) begin
			mid = (lo + hi) / 2;
			if (c.score != score_mem[mid])
				ord = (c.score > score_mem[mid]) ? 1 : -1;
			else if (!c.any && c.etype != type_mem[mid])
				ord = (c.etype > type_mem[mid]) ? 1 : -1;
			else
				ord = 0;
			if (ord == 0)
				res.hit = 1'b1;
			else if (ord > 0)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		res.pos = res.hit ? 9'(mid) : 9'(lo);
		owed_q.push_back(res);
	endfunction

	function void check(logic got_found, logic [8:0] got_pos);
		lookup_t want;
		if (owed_q.size() == 0) begin
			$display("%0t: unexpected result found=%0b position=%0d", $time, got_found, got_pos);
			errors++;
			return;
		end
		want = owed_q.pop_front();
		if (got_found !== want.hit) begin
			$display("%0t: found mismatch: expected %0b, actual %0b", $time, want.hit, got_found);
			errors++;
		end
		if (got_pos !== want.pos) begin
			$display("%0t: position mismatch: expected %0d, actual %0d", $time, want.pos, got_pos);
			errors++;
		end
		if (want.hit)
			hits++;
		else
			misses++;
	endfunction
endclass

module sorted_bucket_search_top_tb;

	localparam int ITEM_TARGET    = 1050;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_e;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic        func        = sbs_pkg::FUNC_WRITE;
	logic [7:0]  slot        = '0;
	logic [63:0] score_a     = '0;
	logic [63:0] score_b     = '0;
	logic [31:0] score_c     = '0;
	logic [7:0]  entry_type  = '0;
	logic        any_type    = 1'b0;
	logic [8:0]  entry_count = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic        found;
	logic [8:0]  position;

	bucket_scoreboard sb = new();

	logic     written [BUCKET];
	int       beats_sent = 0;
	int       burst_left = 0;
	int       idle_cycles = 0;
	rx_mode_e rx_mode = RX_OPEN;
	int       rx_cycle = 0;

	sorted_bucket_search_top #(
		.BUCKET_ENTRIES(BUCKET)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.slot       (slot),
		.score_a    (score_a),
		.score_b    (score_b),
		.score_c    (score_c),
		.entry_type (entry_type),
		.any_type   (any_type),
		.entry_count(entry_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.position   (position)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: switch at intervals to a randomly chosen stall pattern.
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0)
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN: begin
				out_ready <= 1'b1;
			end
			RX_COIN: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			RX_SPARSE: begin
				out_ready <= ($urandom_range(0, 7) == 0);
			end
			default: begin
				out_ready <= (rx_cycle % 8 < 3);
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check(found, position);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles, %0d results owed", $time,
					idle_cycles, sb.owed_q.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic logic [191:0] rand_bits();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [167:0] rand_key();
		logic [191:0] w;
		w = rand_bits();
		return w[167:0];
	endfunction

	// Unused fields get random values; the block must ignore them.
	function automatic sbs_pkg::cmd_t make_write(logic [7:0] s, logic [167:0] k);
		logic [191:0]  w;
		sbs_pkg::cmd_t c;
		w = rand_bits();
		c = sbs_pkg::cmd_t'(w[$bits(sbs_pkg::cmd_t)-1:0]);
		c.is_search = sbs_pkg::FUNC_WRITE;
		c.slot = s;
		{c.score, c.etype} = k;
		return c;
	endfunction

	function automatic sbs_pkg::cmd_t lookup_cmd(logic [167:0] k, logic wild, int cnt);
		logic [191:0]  w;
		sbs_pkg::cmd_t c;
		w = rand_bits();
		c = sbs_pkg::cmd_t'(w[$bits(sbs_pkg::cmd_t)-1:0]);
		c.is_search = sbs_pkg::FUNC_SEARCH;
		{c.score, c.etype} = k;
		c.any = wild;
		c.count = 9'(cnt);
		return c;
	endfunction

	// Pick a count that only covers written slots, and a key near the bucket or at random.
	function automatic sbs_pkg::cmd_t pick_lookup(int n);
		int           span;
		int           cnt;
		int           eff;
		int           idx;
		logic [167:0] near;
		logic [167:0] k;
		logic         wild;
		span = 0;
		while (span < BUCKET && written[span])
			span++;
		case ($urandom_range(0, 9))
			7: cnt = $urandom_range(0, span);
			8: cnt = $urandom_range(0, n);
			9: cnt = (span == BUCKET) ? $urandom_range(BUCKET + 1, 511) : span;
			default: cnt = n;
		endcase
		eff = (cnt > BUCKET) ? BUCKET : cnt;
		idx = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
		near = {sb.score_mem[idx], sb.type_mem[idx]};
		wild = ($urandom_range(0, 4) == 0);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: k = near;
			4: k = {near[167:8], 8'($urandom_range(0, 255))};
			5: k = $urandom_range(0, 1) ? near + 168'd1 : near - 168'd1;
			6: begin
				k = {near[167:8], 8'($urandom_range(0, 255))};
				wild = 1'b1;
			end
			7: k = $urandom_range(0, 1) ? '0 : '1;
			default: k = rand_key() >> $urandom_range(0, 167);
		endcase
		return lookup_cmd(k, wild, cnt);
	endfunction

	// Sender works in bursts; between bursts drop valid for a random gap.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 30);
		gap = $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send(sbs_pkg::cmd_t c);
		func        <= c.is_search ? sbs_pkg::FUNC_SEARCH : sbs_pkg::FUNC_WRITE;
		slot        <= c.slot;
		score_a     <= c.score[159:96];
		score_b     <= c.score[95:32];
		score_c     <= c.score[31:0];
		entry_type  <= c.etype;
		any_type    <= c.any;
		entry_count <= c.count;
		in_valid    <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note(c);
		beats_sent++;
		pace();
	endtask

	// Hold the sender until every owed result is back, then let writes settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Fill slots 0..n-1 with an ascending run, then look it up a few times.
	task automatic run_round(int n);
		logic [167:0] k;
		logic [168:0] nxt;
		logic [7:0]   s;
		int           i;
		k = rand_key() >> $urandom_range(1, 167);
		for (i = 0; i < n; i++) begin
			send(make_write(8'(i), k));
			written[i] = 1'b1;
			// Tiny steps give equal scores with rising types, or duplicates.
			nxt = {1'b0, k} + {1'b0, rand_key() >> $urandom_range(9, 168)};
			k = nxt[168] ? k + 168'd1 : nxt[167:0];
		end
		repeat ($urandom_range(4, 14)) begin
			if ($urandom_range(0, 9) == 0) begin
				// Stray write: may break the ordering of the run.
				s = 8'($urandom_range(0, BUCKET - 1));
				send(make_write(s, rand_key()));
				written[s] = 1'b1;
			end
			send(pick_lookup(n));
		end
	endtask

	initial begin
		logic [167:0] seed [8];
		int           i;
		int           n;
		int           round;
		for (i = 0; i < BUCKET; i++)
			written[i] = 1'b0;
		seed[0] = '0;
		seed[1] = {160'h0, 8'hFF};
		seed[2] = {64'h0, 64'h1, 32'h0, 8'h10};
		seed[3] = {64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'h01};
		seed[4] = {64'h8000_0000_0000_0000, 64'h0, 32'h0, 8'h01};
		seed[5] = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'h5A5A_A5A5, 8'h7F};
		seed[6] = {{160{1'b1}}, 8'h00};
		seed[7] = '1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 8; i++) begin
			send(make_write(8'(i), seed[i]));
			written[i] = 1'b1;
		end
		send(lookup_cmd(seed[3], 1'b0, 0));
		send(lookup_cmd(seed[0], 1'b0, 1));
		send(lookup_cmd(seed[1], 1'b0, 8));
		send(lookup_cmd({160'h0, 8'h80}, 1'b0, 8));
		send(lookup_cmd({160'h0, 8'h80}, 1'b1, 8));
		send(lookup_cmd(seed[7], 1'b0, 8));
		send(lookup_cmd({{160{1'b1}}, 8'h80}, 1'b0, 8));
		send(lookup_cmd(seed[7], 1'b0, 6));
		send(lookup_cmd(seed[4], 1'b0, 8));
		send(lookup_cmd({seed[4][167:8], 8'hEE}, 1'b1, 8));
		send(lookup_cmd(seed[2] + 168'd1, 1'b0, 8));
		send(lookup_cmd(seed[5], 1'b0, 3));
		send(lookup_cmd(seed[5] - 168'd1, 1'b1, 8));
		drain();

		round = 0;
		while (beats_sent < ITEM_TARGET) begin
			if (round == 2 || $urandom_range(0, 79) == 0)
				n = BUCKET;
			else if ($urandom_range(0, 5) == 0)
				n = $urandom_range(17, 64);
			else
				n = $urandom_range(1, 16);
			run_round(n);
			if ($urandom_range(0, 4) == 0)
				drain();
			round++;
		end
		drain();

		sb.errors += sb.owed_q.size();
		$display("Sent %0d beats in %0d rounds; checked %0d lookups (%0d found, %0d missed),",
			beats_sent, round, sb.hits + sb.misses, sb.hits, sb.misses);
		$display("covering full buckets, oversized counts, wildcards and unsorted runs.");
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/sbs_pkg.sv
hw/rtl/sbs_front.sv
hw/rtl/sbs_queue.sv
hw/rtl/sbs_back.sv
hw/rtl/sorted_bucket_search_top.sv
tb/sv/sorted_bucket_search_top_tb.sv
